@@ design/mrkl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mrkl_pkg
// Shared types, codes and the hash step function of the Merkle tree block.
// ----------------------------------------------------------------------------
package mrkl_pkg;

   localparam int ValueWidth     = 64;
   localparam int LeafTotalWidth = 11;
   localparam int StatusWidth    = 2;
   localparam int DefMaxLeaves   = 1024;
   localparam int MixLastStep    = 6;

   localparam logic CmdAppend = 1'b0;
   localparam logic CmdProof  = 1'b1;

   localparam logic [StatusWidth-1:0] StatusOk       = 2'd0;
   localparam logic [StatusWidth-1:0] StatusFull     = 2'd1;
   localparam logic [StatusWidth-1:0] StatusNotFound = 2'd2;

   typedef struct packed {
      logic                  cmd;
      logic [ValueWidth-1:0] value;
   } req_type;

   typedef struct packed {
      logic [ValueWidth-1:0]     root_hash;
      logic [ValueWidth-1:0]     proof_hash;
      logic [LeafTotalWidth-1:0] leaf_total;
      logic [StatusWidth-1:0]    status;
      logic                      last;
   } rsp_type;

   // One step of the 64-bit shift hash; steps run from zero to MixLastStep.
   function automatic logic [ValueWidth-1:0] mix_step(input logic [ValueWidth-1:0] k,
                                                      input logic [2:0] step);
      logic [ValueWidth-1:0] r;
      case (step)
         3'd0:    r = (~k) + (k << 21);
         3'd1:    r = k ^ (k >> 24);
         3'd2:    r = (k + (k << 3)) + (k << 8);
         3'd3:    r = k ^ (k >> 14);
         3'd4:    r = (k + (k << 2)) + (k << 4);
         3'd5:    r = k ^ (k >> 28);
         3'd6:    r = k + (k << 31);
         default: r = k;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

@@ design/merkle_append_and_proof.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// merkle_append_and_proof
// Append-only Merkle tree of 64-bit leaves with root and proof generation.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; every result is
// shown for one cycle with rsp_valid high and cannot be held off. The node
// store is one RAM with a registered read port. An append walks each level
// through a level check and a write, with a sibling read and seven hash
// steps in between where the level has a sibling. A proof scans the leaves
// at one per cycle through the RAM read port, then emits one proof result
// per level.
module merkle_append_and_proof #(
   parameter int MAX_LEAVES = mrkl_pkg::DefMaxLeaves
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire mrkl_pkg::req_type req_data,
   output logic                   rsp_valid,
   output mrkl_pkg::rsp_type      rsp_data
);
   import mrkl_pkg::*;

   localparam int Depth = 2 * MAX_LEAVES + 64;
   localparam int AW    = $clog2(Depth);
   localparam int CW    = $clog2(MAX_LEAVES + 1);

   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StALevel = 3'd1;
   localparam logic [2:0] StAWait  = 3'd2;
   localparam logic [2:0] StAMix   = 3'd3;
   localparam logic [2:0] StAWrite = 3'd4;
   localparam logic [2:0] StPScan  = 3'd5;
   localparam logic [2:0] StPLevel = 3'd6;
   localparam logic [2:0] StPEmit  = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [ValueWidth-1:0] root_ff, root_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         size_ff, size_in;
   logic [CW-1:0]         cap_ff, cap_in;
   logic [AW-1:0]         base_ff, base_in;
   logic [ValueWidth-1:0] cur_ff, cur_in;
   logic [ValueWidth-1:0] key_ff, key_in;
   logic [2:0]            step_ff, step_in;
   logic [CW-1:0]         scan_ff, scan_in;
   logic [CW-1:0]         scan_i_ff, scan_i_in;
   logic                  scan_v_ff, scan_v_in;
   logic                  have_ff, have_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  ram_we;
   logic [AW-1:0]         ram_waddr, ram_raddr;
   logic [ValueWidth-1:0] ram_wdata, ram_rdata;

   logic [CW-1:0]         size_up, cap_up, idx_up;
   logic [AW-1:0]         base_up;

   mrkl_ram #(.WIDTH(ValueWidth), .DEPTH(Depth)) u_node_store (
      .clock    (clock),
      .we       (ram_we),
      .waddr    (ram_waddr),
      .wdata    (ram_wdata),
      .raddr    (ram_raddr),
      .rdata_ff (ram_rdata)
   );

   assign size_up = CW'(({1'b0, size_ff} + (CW+1)'(1)) >> 1);
   assign cap_up  = CW'(({1'b0, cap_ff} + (CW+1)'(1)) >> 1);
   assign idx_up  = idx_ff >> 1;
   assign base_up = base_ff + AW'(cap_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      root_in      = root_ff;
      idx_in       = idx_ff;
      size_in      = size_ff;
      cap_in       = cap_ff;
      base_in      = base_ff;
      cur_in       = cur_ff;
      key_in       = key_ff;
      step_in      = step_ff;
      scan_in      = scan_ff;
      scan_i_in    = scan_i_ff;
      scan_v_in    = 1'b0;
      have_in      = have_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = base_up + AW'(idx_up);
      ram_wdata    = cur_ff;
      ram_raddr    = base_ff + AW'(idx_ff) - AW'(1);

      case (state_ff)
         StIdle: begin
            if (start) begin
               key_in = req_data.value;
               if (req_data.cmd == CmdAppend) begin
                  if (count_ff == CW'(MAX_LEAVES)) begin
                     rsp_valid_in      = 1'b1;
                     rsp_in.root_hash  = root_ff;
                     rsp_in.proof_hash = '0;
                     rsp_in.leaf_total = LeafTotalWidth'(count_ff);
                     rsp_in.status     = StatusFull;
                     rsp_in.last       = 1'b1;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = AW'(count_ff);
                     ram_wdata = req_data.value;
                     idx_in    = count_ff;
                     size_in   = count_ff + CW'(1);
                     count_in  = count_ff + CW'(1);
                     base_in   = '0;
                     cap_in    = CW'(MAX_LEAVES);
                     cur_in    = req_data.value;
                     state_in  = StALevel;
                  end
               end else begin
                  if (count_ff == '0) begin
                     rsp_valid_in      = 1'b1;
                     rsp_in.root_hash  = root_ff;
                     rsp_in.proof_hash = '0;
                     rsp_in.leaf_total = LeafTotalWidth'(count_ff);
                     rsp_in.status     = StatusNotFound;
                     rsp_in.last       = 1'b1;
                  end else begin
                     scan_in  = '0;
                     state_in = StPScan;
                  end
               end
            end
         end
         StALevel: begin
            if (size_ff <= CW'(1)) begin
               root_in           = cur_ff;
               rsp_valid_in      = 1'b1;
               rsp_in.root_hash  = cur_ff;
               rsp_in.proof_hash = '0;
               rsp_in.leaf_total = LeafTotalWidth'(count_ff);
               rsp_in.status     = StatusOk;
               rsp_in.last       = 1'b1;
               state_in          = StIdle;
            end else if (idx_ff[0]) begin
               state_in = StAWait;
            end else begin
               state_in = StAWrite;
            end
         end
         StAWait: begin
            cur_in   = ram_rdata + cur_ff;
            step_in  = '0;
            state_in = StAMix;
         end
         StAMix: begin
            cur_in  = mix_step(cur_ff, step_ff);
            step_in = step_ff + 3'd1;
            if (step_ff == 3'(MixLastStep)) begin
               state_in = StAWrite;
            end
         end
         StAWrite: begin
            ram_we   = 1'b1;
            base_in  = base_up;
            cap_in   = cap_up;
            size_in  = size_up;
            idx_in   = idx_up;
            state_in = StALevel;
         end
         StPScan: begin
            ram_raddr = AW'(scan_ff);
            scan_v_in = (scan_ff < count_ff);
            scan_i_in = scan_ff;
            scan_in   = scan_ff + CW'(1);
            if (scan_v_ff && ram_rdata == key_ff) begin
               idx_in   = scan_i_ff;
               size_in  = count_ff;
               base_in  = '0;
               cap_in   = CW'(MAX_LEAVES);
               state_in = StPLevel;
            end else if (scan_v_ff && scan_i_ff == count_ff - CW'(1)) begin
               rsp_valid_in      = 1'b1;
               rsp_in.root_hash  = root_ff;
               rsp_in.proof_hash = '0;
               rsp_in.leaf_total = LeafTotalWidth'(count_ff);
               rsp_in.status     = StatusNotFound;
               rsp_in.last       = 1'b1;
               state_in          = StIdle;
            end
         end
         StPLevel: begin
            if (size_ff == CW'(1)) begin
               rsp_valid_in      = 1'b1;
               rsp_in.root_hash  = root_ff;
               rsp_in.proof_hash = '0;
               rsp_in.leaf_total = LeafTotalWidth'(count_ff);
               rsp_in.status     = StatusOk;
               rsp_in.last       = 1'b1;
               state_in          = StIdle;
            end else begin
               if (idx_ff[0]) begin
                  have_in = 1'b1;
               end else if (idx_ff + CW'(1) < size_ff) begin
                  ram_raddr = base_ff + AW'(idx_ff) + AW'(1);
                  have_in   = 1'b1;
               end else begin
                  have_in = 1'b0;
               end
               state_in = StPEmit;
            end
         end
         StPEmit: begin
            rsp_valid_in      = 1'b1;
            rsp_in.root_hash  = root_ff;
            rsp_in.proof_hash = have_ff ? ram_rdata : '0;
            rsp_in.leaf_total = LeafTotalWidth'(count_ff);
            rsp_in.status     = StatusOk;
            rsp_in.last       = (size_up == CW'(1));
            base_in           = base_up;
            cap_in            = cap_up;
            size_in           = size_up;
            idx_in            = idx_up;
            state_in          = (size_up == CW'(1)) ? StIdle : StPLevel;
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         count_ff     <= '0;
         root_ff      <= '0;
         scan_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         root_ff      <= root_in;
         scan_v_ff    <= scan_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      size_ff   <= size_in;
      cap_ff    <= cap_in;
      base_ff   <= base_in;
      cur_ff    <= cur_in;
      key_ff    <= key_in;
      step_ff   <= step_in;
      scan_ff   <= scan_in;
      scan_i_ff <= scan_i_in;
      have_ff   <= have_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != StIdle);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

@@ design/mrkl_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mrkl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mrkl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2112
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

@@ test/merkle_append_and_proof_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// merkle_append_and_proof_test
// Drives append and proof requests into the Merkle tree block with random
// gaps, predicts results from a software tree copy or fixed rows, and checks
// each result field by field. A directed table runs first, then random traffic.
// ----------------------------------------------------------------------------
module merkle_append_and_proof_test;
   import mrkl_pkg::*;

   localparam int MaxLeaves = DefMaxLeaves;
   localparam int NodeDepth = 2 * MaxLeaves + 64;
   localparam int RandomRequests = 444;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   logic [ValueWidth-1:0] tree_nodes [NodeDepth];
   int unsigned           leaf_cnt;
   logic [ValueWidth-1:0] root_val;
   logic [ValueWidth-1:0] leaf_values [$];
   rsp_type               expected_rsp [$];
   int                    error_count;

   merkle_append_and_proof dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("FAIL");
      $finish;
   end

   function automatic logic [ValueWidth-1:0] shift_hash(input logic [ValueWidth-1:0] k);
      k = (~k) + (k << 21);
      k = k ^ (k >> 24);
      k = (k + (k << 3)) + (k << 8);
      k = k ^ (k >> 14);
      k = (k + (k << 2)) + (k << 4);
      k = k ^ (k >> 28);
      k = k + (k << 31);
      return k;
   endfunction

   function automatic rsp_type make_rsp(input logic [ValueWidth-1:0] proof,
                                        input logic [StatusWidth-1:0] status,
                                        input logic last);
      rsp_type r;
      r.root_hash  = root_val;
      r.proof_hash = proof;
      r.leaf_total = leaf_cnt[LeafTotalWidth-1:0];
      r.status     = status;
      r.last       = last;
      return r;
   endfunction

   // Updates the tree copy and returns the results one request causes.
   function automatic void tree_update(input req_type req, ref rsp_type outs[$]);
      int unsigned idx, size, base, cap, i;
      logic [ValueWidth-1:0] node, sib;
      bit found;
      outs = {};
      if (req.cmd == CmdAppend) begin
         if (leaf_cnt >= MaxLeaves) begin
            outs.insert(outs.size(), make_rsp('0, StatusFull, 1'b1));
            return;
         end
         idx = leaf_cnt;
         tree_nodes[idx] = req.value;
         leaf_cnt++;
         size = leaf_cnt;
         base = 0;
         cap = MaxLeaves;
         while (size > 1) begin
            i = idx & ~32'd1;
            if ((i | 1) < size) begin
               node = shift_hash(tree_nodes[base + i] + tree_nodes[base + i + 1]);
            end else begin
               node = tree_nodes[base + i];
            end
            base += cap;
            cap = (cap + 1) >> 1;
            size = (size + 1) >> 1;
            idx >>= 1;
            tree_nodes[base + idx] = node;
         end
         root_val = tree_nodes[base + idx];
         outs.insert(outs.size(), make_rsp('0, StatusOk, 1'b1));
         return;
      end
      found = 0;
      idx = 0;
      for (i = 0; i < leaf_cnt && !found; i++) begin
         if (tree_nodes[i] == req.value) begin
            idx = i;
            found = 1;
         end
      end
      if (!found) begin
         outs.insert(outs.size(), make_rsp('0, StatusNotFound, 1'b1));
         return;
      end
      size = leaf_cnt;
      if (size == 1) begin
         outs.insert(outs.size(), make_rsp('0, StatusOk, 1'b1));
         return;
      end
      base = 0;
      cap = MaxLeaves;
      while (size > 1) begin
         if (idx & 1) begin
            sib = tree_nodes[base + idx - 1];
         end else if (idx + 1 < size) begin
            sib = tree_nodes[base + idx + 1];
         end else begin
            sib = '0;
         end
         base += cap;
         cap = (cap + 1) >> 1;
         size = (size + 1) >> 1;
         idx >>= 1;
         outs.insert(outs.size(), make_rsp(sib, StatusOk, size == 1));
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [ValueWidth-1:0] got,
                                  input logic [ValueWidth-1:0] want);
      if (error_count < 30) begin
         $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
      end
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected result, root", rsp_data.root_hash, '0);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.root_hash !== want.root_hash)
               report_mismatch("root_hash", rsp_data.root_hash, want.root_hash);
            if (rsp_data.proof_hash !== want.proof_hash)
               report_mismatch("proof_hash", rsp_data.proof_hash, want.proof_hash);
            if (rsp_data.leaf_total !== want.leaf_total)
               report_mismatch("leaf_total", rsp_data.leaf_total, want.leaf_total);
            if (rsp_data.status !== want.status)
               report_mismatch("status", rsp_data.status, want.status);
            if (rsp_data.last !== want.last)
               report_mismatch("last", rsp_data.last, want.last);
         end
      end
   end

   // Issues one request after a random gap and records what it must cause.
   task automatic send_request(input req_type req, input bit typed, input rsp_type fixed);
      int unsigned gap;
      rsp_type outs[$];
      gap = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= req;
      do @(posedge clock); while (busy !== 1'b0);
      tree_update(req, outs);
      if (req.cmd == CmdAppend && req.value inside {leaf_values} == 0)
         leaf_values.insert(leaf_values.size(), req.value);
      if (typed) begin
         expected_rsp.insert(expected_rsp.size(), fixed);
      end else begin
         foreach (outs[i]) expected_rsp.insert(expected_rsp.size(), outs[i]);
      end
   endtask

   function automatic req_type make_req(input logic cmd, input logic [ValueWidth-1:0] v);
      req_type r;
      r.cmd   = cmd;
      r.value = v;
      return r;
   endfunction

   function automatic logic [ValueWidth-1:0] random_value();
      return {$urandom(), $urandom()};
   endfunction

   initial begin
      stim_row_type rows[$];
      rsp_type none;
      req_type req;
      int unsigned waited;
      none = '0;
      error_count = 0;
      leaf_cnt = 0;
      root_val = '0;
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;

      rows.insert(rows.size(), '{make_req(CmdProof, '0), 1,
                                 '{'0, '0, 11'd0, StatusNotFound, 1'b1}});
      rows.insert(rows.size(), '{make_req(CmdAppend, '0), 1,
                                 '{'0, '0, 11'd1, StatusOk, 1'b1}});
      rows.insert(rows.size(), '{make_req(CmdProof, '0), 1,
                                 '{'0, '0, 11'd1, StatusOk, 1'b1}});
      rows.insert(rows.size(), '{make_req(CmdProof, '1), 1,
                                 '{'0, '0, 11'd1, StatusNotFound, 1'b1}});
      rows.insert(rows.size(), '{make_req(CmdAppend, '1), 0, none});
      rows.insert(rows.size(), '{make_req(CmdProof, '1), 0, none});
      rows.insert(rows.size(), '{make_req(CmdAppend, 64'h8000_0000_0000_0000), 0, none});
      rows.insert(rows.size(), '{make_req(CmdProof, '0), 0, none});
      rows.insert(rows.size(), '{make_req(CmdProof, 64'h8000_0000_0000_0000), 0, none});
      rows.insert(rows.size(), '{make_req(CmdAppend, '0), 0, none});
      rows.insert(rows.size(), '{make_req(CmdProof, '0), 0, none});
      rows.insert(rows.size(), '{make_req(CmdAppend, 64'h0000_0000_0000_0001), 0, none});
      rows.insert(rows.size(), '{make_req(CmdAppend, 64'h5555_5555_5555_5555), 0, none});
      rows.insert(rows.size(), '{make_req(CmdAppend, 64'hAAAA_AAAA_AAAA_AAAA), 0, none});
      rows.insert(rows.size(), '{make_req(CmdProof, 64'h5555_5555_5555_5555), 0, none});
      rows.insert(rows.size(), '{make_req(CmdProof, 64'hAAAA_AAAA_AAAA_AAAA), 0, none});
      rows.insert(rows.size(), '{make_req(CmdProof, 64'h0000_0000_0000_0001), 0, none});
      rows.insert(rows.size(), '{make_req(CmdProof, 64'h1234_5678_9ABC_DEF0), 0, none});

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].rsp);

      for (int n = 0; n < RandomRequests; n++) begin
         req.cmd = ($urandom_range(0, 9) < 6) ? CmdAppend : CmdProof;
         if (req.cmd == CmdAppend) begin
            req.value = ($urandom_range(0, 9) == 0) ?
                        leaf_values[$urandom_range(0, leaf_values.size() - 1)] :
                        random_value();
         end else begin
            req.value = ($urandom_range(0, 4) == 0) ? random_value() :
                        leaf_values[$urandom_range(0, leaf_values.size() - 1)];
         end
         send_request(req, 0, none);
      end

      for (int n = 0; n < 8; n++) begin
         req.cmd = n[0] ? CmdProof : CmdAppend;
         req.value = (n == 3) ? tree_nodes[leaf_cnt - 1] :
                     (n == 5) ? random_value() :
                     leaf_values[$urandom_range(0, leaf_values.size() - 1)];
         send_request(req, 0, none);
      end
      start <= 1'b0;

      while (expected_rsp.size() != 0) @(posedge clock);
      waited = 0;
      while (waited < 200) begin
         @(posedge clock);
         waited++;
      end
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
